// ----- rtl/lkv_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared types and constants for the fully associative LRU key/value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

    // Request operation codes.
    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_op;

    // Fixed payload widths.
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    // Value returned by a get that misses (-1 in two's complement).
    localparam logic signed [VAL_W-1:0] READ_MISS = '1;

    // Capacity register value after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Recency update command from the cache core to the rank table.
    typedef struct packed {
        logic touch;   // move the hit entry to most recent
        logic insert;  // age every surviving entry, new entry becomes most recent
    } t_rank_cmd;

endpackage

// ----- rtl/lkv_req_if.sv -----
// ----------------------------------------------------------------------------
// LRU cache request interface
// Valid/ready channel that carries one get or put request per transaction.
// ----------------------------------------------------------------------------
interface lkv_req_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [31:0] lookup_key;
    logic signed [31:0] write_value;

    modport source (output valid, output operation, output lookup_key,
                    output write_value, input ready);
    modport sink   (input valid, input operation, input lookup_key,
                    input write_value, output ready);
endinterface

// ----- rtl/lkv_rsp_if.sv -----
// ----------------------------------------------------------------------------
// LRU cache response interface
// Valid/ready channel that carries one result per transaction.
// ----------------------------------------------------------------------------
interface lkv_rsp_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

// ----- rtl/lkv_lookup.sv -----
// ----------------------------------------------------------------------------
// LRU cache lookup
// Compares the request key against every valid entry in parallel and picks
// the lowest-numbered slot that is free once the evicted entry is removed.
// ----------------------------------------------------------------------------
module lkv_lookup #(
    parameter int ENTRIES = 16
) (
    input  logic [ENTRIES-1:0][lkv_pkg::KEY_W-1:0] i_keys,
    input  logic [ENTRIES-1:0]                     i_valid,
    input  logic [lkv_pkg::KEY_W-1:0]              i_key,
    input  logic [ENTRIES-1:0]                     i_evict_vec,
    output logic [ENTRIES-1:0]                     o_hit_vec,
    output logic                                   o_hit,
    output logic [ENTRIES-1:0]                     o_free_vec
);
    import lkv_pkg::*;

    logic [ENTRIES-1:0] w_avail;
    logic               w_found;

    // Parallel key match against valid entries.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            o_hit_vec[i] = i_valid[i] && (i_keys[i] == i_key);
        end
    end

    assign o_hit   = |o_hit_vec;
    assign w_avail = ~(i_valid & ~i_evict_vec);

    // Lowest-numbered free slot as a one-hot vector.
    always_comb begin
        o_free_vec = '0;
        w_found    = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_avail[i] && !w_found) begin
                o_free_vec[i] = 1'b1;
                w_found       = 1'b1;
            end
        end
    end

endmodule

// ----- rtl/lkv_recency.sv -----
// ----------------------------------------------------------------------------
// LRU cache recency table
// Holds one recency rank per entry (0 = most recent) and finds the least
// recent valid entry, whose rank is always the entry count minus one.
// ----------------------------------------------------------------------------
module lkv_recency #(
    parameter int ENTRIES = 16,
    parameter int RANK_W  = 4,
    parameter int CNT_W   = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lkv_pkg::t_rank_cmd        i_cmd,
    input  logic [ENTRIES-1:0]        i_valid,
    input  logic [ENTRIES-1:0]        i_hit_vec,
    input  logic [ENTRIES-1:0]        i_evict_vec,
    input  logic [ENTRIES-1:0]        i_free_vec,
    input  logic [CNT_W-1:0]          i_count,
    output logic [ENTRIES-1:0]        o_victim_vec
);
    import lkv_pkg::*;

    logic [ENTRIES-1:0][RANK_W-1:0] r_rank;
    logic [ENTRIES-1:0][RANK_W-1:0] n_rank;
    logic [RANK_W-1:0]              w_hit_rank;
    logic [CNT_W-1:0]               w_last;
    logic [RANK_W-1:0]              w_last_rank;

    // The oldest entry carries rank count - 1.
    assign w_last      = i_count - CNT_W'(1);
    assign w_last_rank = w_last[RANK_W-1:0];

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            o_victim_vec[i] = i_valid[i] && (r_rank[i] == w_last_rank);
        end
    end

    // Rank of the hit entry; at most one entry matches.
    always_comb begin
        w_hit_rank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_hit_vec[i]) begin
                w_hit_rank = w_hit_rank | r_rank[i];
            end
        end
    end

    // Next ranks for a touch or an insert.
    always_comb begin
        n_rank = r_rank;
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_cmd.touch) begin
                if (i_hit_vec[i]) begin
                    n_rank[i] = '0;
                end else if (i_valid[i] && (r_rank[i] < w_hit_rank)) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end else if (i_cmd.insert) begin
                if (i_free_vec[i]) begin
                    n_rank[i] = '0;
                end else if (i_valid[i] && !i_evict_vec[i]) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= '0;
        end else begin
            r_rank <= n_rank;
        end
    end

endmodule

// ----- rtl/lru_key_value_cache_core.sv -----
// ----------------------------------------------------------------------------
// LRU key/value cache core
// Fully associative key/value store with least-recently-used replacement.
//
//   Channel   Dir  Handshake            Payload
//   i_req     in   valid/ready          operation, lookup_key, write_value
//   o_rsp     out  valid/ready          hit, read_value
//   i_cfg_*   in   write enable, data   capacity_limit (5 bits)
//
// Each request waits in the input register, where the key match and rank
// update run, and its result is then held in the result register.
// o_rsp.valid therefore rises once the result register is loaded. One request
// per cycle is sustained while o_rsp.ready stays high. Reset (synchronous,
// active low) clears all valid marks, ranks and the entry count and sets the
// capacity to 16. A stalled response holds the result register, and the input
// register accepts a new request only when its current one can move on.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
    parameter int ENTRIES = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    lkv_req_if.sink                   i_req,
    lkv_rsp_if.source                 o_rsp,
    input  logic                      i_cfg_wr_en,
    input  logic [lkv_pkg::CAP_W-1:0] i_cfg_wr_data
);
    import lkv_pkg::*;

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Configuration.
    logic [CAP_W-1:0] r_cap;

    // Input register.
    logic             r_in_valid;
    t_op              r_in_op;
    logic [KEY_W-1:0] r_in_key;
    logic [VAL_W-1:0] r_in_val;

    // Result register.
    logic             r_out_valid;
    logic             r_out_hit;
    logic [VAL_W-1:0] r_out_val;
    logic             n_out_hit;
    logic [VAL_W-1:0] n_out_val;

    // Entry storage.
    logic [ENTRIES-1:0][KEY_W-1:0] r_key;
    logic [ENTRIES-1:0][VAL_W-1:0] r_value;
    logic [ENTRIES-1:0]            r_valid;
    logic [CNT_W-1:0]              r_count;
    logic [ENTRIES-1:0]            n_valid;
    logic [CNT_W-1:0]              n_count;

    // Lookup and update control.
    logic               w_fire;
    logic [ENTRIES-1:0] w_hit_vec;
    logic               w_hit;
    logic [ENTRIES-1:0] w_free_vec;
    logic [ENTRIES-1:0] w_victim_vec;
    logic [ENTRIES-1:0] w_evict_vec;
    logic [VAL_W-1:0]   w_hit_val;
    logic [CAP_W-1:0]   w_cap_min1;
    logic               w_full;
    logic               w_put_hit;
    logic               w_put_miss;
    logic               w_evict;
    t_rank_cmd          w_cmd;

    // Handshake: the stage fires when the result register can take a result.
    assign w_fire      = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_fire;

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.read_value = r_out_val;

    // Capacity of zero acts as one; a capacity above ENTRIES saturates.
    assign w_cap_min1 = (r_cap == '0) ? CAP_W'(1) : r_cap;
    assign w_full     = (CMP_W'(r_count) >= CMP_W'(ENTRIES))
                     || (CMP_W'(r_count) >= CMP_W'(w_cap_min1));

    assign w_put_hit   = w_fire && (r_in_op == OP_PUT) && w_hit;
    assign w_put_miss  = w_fire && (r_in_op == OP_PUT) && !w_hit;
    assign w_evict     = w_put_miss && w_full;
    assign w_evict_vec = w_evict ? w_victim_vec : '0;

    assign w_cmd.touch  = w_fire && w_hit;
    assign w_cmd.insert = w_put_miss;

    lkv_lookup #(
        .ENTRIES (ENTRIES)
    ) u_lookup (
        .i_keys      (r_key),
        .i_valid     (r_valid),
        .i_key       (r_in_key),
        .i_evict_vec (w_evict_vec),
        .o_hit_vec   (w_hit_vec),
        .o_hit       (w_hit),
        .o_free_vec  (w_free_vec)
    );

    lkv_recency #(
        .ENTRIES (ENTRIES),
        .RANK_W  (RANK_W),
        .CNT_W   (CNT_W)
    ) u_recency (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_valid      (r_valid),
        .i_hit_vec    (w_hit_vec),
        .i_evict_vec  (w_evict_vec),
        .i_free_vec   (w_free_vec),
        .i_count      (r_count),
        .o_victim_vec (w_victim_vec)
    );

    // Value of the hit entry, selected by the one-hot match vector.
    always_comb begin
        w_hit_val = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_hit_vec[i]) begin
                w_hit_val = w_hit_val | r_value[i];
            end
        end
    end

    // Result of the current request.
    always_comb begin
        n_out_hit = w_hit;
        if (r_in_op == OP_GET) begin
            n_out_val = w_hit ? w_hit_val : READ_MISS;
        end else begin
            n_out_val = '0;
        end
    end

    // Valid marks and entry count after an eviction and an insert.
    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        if (w_put_miss) begin
            n_valid = (r_valid & ~w_evict_vec) | w_free_vec;
            if (!w_evict) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_count     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            r_valid <= n_valid;
            r_count <= n_count;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_op  <= t_op'(i_req.operation);
            r_in_key <= i_req.lookup_key;
            r_in_val <= i_req.write_value;
        end
        if (w_fire) begin
            r_out_hit <= n_out_hit;
            r_out_val <= n_out_val;
        end
    end

    // Entry key and value writes.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_put_miss && w_free_vec[i]) begin
                r_key[i]   <= r_in_key;
                r_value[i] <= r_in_val;
            end else if (w_put_hit && w_hit_vec[i]) begin
                r_value[i] <= r_in_val;
            end
        end
    end

endmodule
